[design/lfl_pkg.sv]
// shared types and constants of the linked free-list block allocator
package lfl_pkg;

    localparam int BLK_W  = 12;
    localparam int TOT_W  = 13;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    localparam logic [BLK_W-1:0] FIRST_FREE  = 12'd3;
    localparam logic [BLK_W-1:0] COUNT_MAX   = 12'hfff;
    localparam logic [TOT_W-1:0] TOTAL_RESET = 13'd4096;
    localparam logic [TOT_W-1:0] TOTAL_MIN   = 13'd4;

    // register index of total_blocks
    localparam logic REG_TOTAL = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FORMAT = 2'd0,
        FUNC_ALLOC  = 2'd1,
        FUNC_FREE   = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_BLOCK = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMT,
        S_ALLOC,
        S_FREE,
        S_DONE
    } t_state;

endpackage

[design/lfl_if.sv]
// request and result channel interfaces of the allocator
interface lfl_in_if import lfl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BLK_W-1:0]  block_in;

    modport source (output valid, output func, output block_in, input ready);
    modport sink   (input valid, input func, input block_in, output ready);
endinterface

interface lfl_out_if import lfl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BLK_W-1:0]  block_out;
    logic [BLK_W-1:0]  free_count;
    logic [STAT_W-1:0] status;

    modport source (output valid, output block_out, output free_count, output status,
                    input ready);
    modport sink   (input valid, input block_out, input free_count, input status,
                    output ready);
endinterface

[design/linked_free_list_block_allocator_top.sv]
// top level of the linked free-list block allocator
//
// usage
//   requests arrive on i_in (func, block_in) and results leave on o_out
//   (block_out, free_count, status), both valid/ready channels; an item
//   moves when valid and ready are high at a rising edge; the user writes
//   total_blocks through the apb port at byte address 0 only while idle,
//   not enforced by the block; it is clamped to 4 .. MAX_BLOCKS when used
// sequence
//   one item is in flight at a time; the single link memory port sets the
//   pace: allocate reads the head link, then updates; free writes the tail
//   link if the list is not empty, then the new block link; rejected or
//   empty requests and the unused code finish on accept, and format has
//   the accept step plus one link write per block
// reset
//   synchronous, active low; head, tail and count clear and total_blocks
//   returns to 4096; the link memory is not cleared, so a format is expected
// stall
//   a finished result waits in the output register while a new item is taken;
//   a second one parks in a holding register and stalls the input until it drains
module linked_free_list_block_allocator_top import lfl_pkg::*; #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfl_in_if.sink      i_in,
    lfl_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    // address width wide enough for both a block number and the format counter
    localparam int XW = (AW > TOT_W) ? AW : TOT_W;
    localparam logic [16:0] MAX_W = 17'(MAX_BLOCKS);

    // control state
    t_state           r_state, n_state;
    logic [BLK_W-1:0] r_head, n_head;
    logic [BLK_W-1:0] r_tail, n_tail;
    logic [BLK_W-1:0] r_count, n_count;
    logic [TOT_W-1:0] r_total;
    logic [TOT_W-1:0] r_fmt_b, n_fmt_b;
    logic [BLK_W-1:0] r_blk, n_blk;
    logic             r_out_valid, n_out_valid;

    // result payload
    logic [BLK_W-1:0]  r_out_block, r_out_count;
    logic [STAT_W-1:0] r_out_status;
    logic [BLK_W-1:0]  r_pend_block, r_pend_count;
    logic [STAT_W-1:0] r_pend_status;

    logic              w_in_acc;
    logic              w_slot_free;
    t_func             w_func;
    logic [TOT_W-1:0]  w_total_eff;
    logic              w_blk_ok;
    logic              w_empty;
    logic [TOT_W-1:0]  w_fmt_next;
    logic              w_fmt_last;
    logic              w_finish;
    logic [BLK_W-1:0]  w_res_block, w_res_count;
    t_status           w_res_status;

    logic              w_mem_we;
    logic [XW-1:0]     w_mem_addr_x;
    logic [BLK_W-1:0]  w_mem_wdata;
    logic [BLK_W-1:0]  w_mem_rdata;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_func      = t_func'(i_in.func);
    assign w_empty     = (r_count == '0);

    // clamp of the programmed total
    always_comb begin
        if (r_total < TOTAL_MIN) begin
            w_total_eff = TOTAL_MIN;
        end else if ({4'b0, r_total} > MAX_W) begin
            w_total_eff = MAX_W[TOT_W-1:0];
        end else begin
            w_total_eff = r_total;
        end
    end

    // reserved blocks and blocks past the device end are refused
    assign w_blk_ok   = (i_in.block_in >= FIRST_FREE) &&
                        ({1'b0, i_in.block_in} < w_total_eff);
    assign w_fmt_next = r_fmt_b + 13'd1;
    assign w_fmt_last = (w_fmt_next >= w_total_eff);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_func)
                        FUNC_FORMAT: n_state = S_FMT;
                        FUNC_ALLOC:  n_state = w_empty ? (w_slot_free ? S_IDLE : S_DONE)
                                                       : S_ALLOC;
                        FUNC_FREE:   n_state = w_blk_ok ? S_FREE
                                                        : (w_slot_free ? S_IDLE : S_DONE);
                        FUNC_NOP:    n_state = w_slot_free ? S_IDLE : S_DONE;
                    endcase
                end
            end
            S_FMT: begin
                if (w_fmt_last) begin
                    n_state = w_slot_free ? S_IDLE : S_DONE;
                end
            end
            S_ALLOC, S_FREE: n_state = w_slot_free ? S_IDLE : S_DONE;
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_fmt_b      = r_fmt_b;
        n_blk        = r_blk;
        w_mem_we     = 1'b0;
        w_mem_addr_x = XW'(r_head);
        w_mem_wdata  = '0;
        w_finish     = 1'b0;
        w_res_block  = '0;
        w_res_count  = r_count;
        w_res_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_func)
                        FUNC_FORMAT: n_fmt_b = {1'b0, FIRST_FREE};
                        FUNC_ALLOC: begin
                            // read of the head link goes out on accept
                            if (w_empty) begin
                                w_finish     = 1'b1;
                                w_res_status = ST_EMPTY;
                            end
                        end
                        FUNC_FREE: begin
                            if (!w_blk_ok) begin
                                w_finish     = 1'b1;
                                w_res_status = ST_BAD_BLOCK;
                            end else begin
                                n_blk = i_in.block_in;
                                // chain the new block behind the tail
                                if (!w_empty) begin
                                    w_mem_we     = 1'b1;
                                    w_mem_addr_x = XW'(r_tail);
                                    w_mem_wdata  = i_in.block_in;
                                end
                            end
                        end
                        FUNC_NOP: w_finish = 1'b1;
                    endcase
                end
            end
            S_FMT: begin
                w_mem_we     = 1'b1;
                w_mem_addr_x = XW'(r_fmt_b);
                w_mem_wdata  = w_fmt_last ? '0 : w_fmt_next[BLK_W-1:0];
                n_fmt_b      = w_fmt_next;
                if (w_fmt_last) begin
                    n_head      = FIRST_FREE;
                    n_tail      = r_fmt_b[BLK_W-1:0];
                    n_count     = w_total_eff[BLK_W-1:0] - FIRST_FREE;
                    w_finish    = 1'b1;
                    w_res_count = n_count;
                end
            end
            S_ALLOC: begin
                n_head      = w_mem_rdata;
                n_count     = r_count - 12'd1;
                w_finish    = 1'b1;
                w_res_block = r_head;
                w_res_count = n_count;
            end
            S_FREE: begin
                // the freed block ends the list; this write wins on a double free
                w_mem_we     = 1'b1;
                w_mem_addr_x = XW'(r_blk);
                w_mem_wdata  = '0;
                n_tail       = r_blk;
                if (w_empty) begin
                    n_head = r_blk;
                end
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + 12'd1;
                end
                w_finish    = 1'b1;
                w_res_count = n_count;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if ((w_finish || (r_state == S_DONE)) && w_slot_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_total     <= TOTAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL)) begin
                r_total <= pwdata[TOT_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fmt_b <= n_fmt_b;
        r_blk   <= n_blk;
        if (w_finish && w_slot_free) begin
            r_out_block  <= w_res_block;
            r_out_count  <= w_res_count;
            r_out_status <= w_res_status;
        end else if ((r_state == S_DONE) && w_slot_free) begin
            r_out_block  <= r_pend_block;
            r_out_count  <= r_pend_count;
            r_out_status <= r_pend_status;
        end
        if (w_finish && !w_slot_free) begin
            r_pend_block  <= w_res_block;
            r_pend_count  <= w_res_count;
            r_pend_status <= w_res_status;
        end
    end

    lfl_link_ram #(
        .AW (AW),
        .DW (BLK_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr_x[AW-1:0]),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.block_out  = r_out_block;
    assign o_out.free_count = r_out_count;
    assign o_out.status     = r_out_status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOTAL) ? {{(32-TOT_W){1'b0}}, r_total} : 32'd0;

`ifndef SYNTHESIS
    // a non-empty allocate goes to the link read state
    a_alloc_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_func == FUNC_ALLOC) && !w_empty) |=> (r_state == S_ALLOC))
        else $error("allocate did not enter link read");

    // a completed allocate takes exactly one block off the count
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |=> (r_count == $past(r_count) - 12'd1))
        else $error("allocate count mismatch");

    // the link read cycle must not be disturbed by a write
    a_alloc_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> !w_mem_we)
        else $error("link write during allocate read");

    // a parked result only exists behind a full output register
    a_park_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_out_valid)
        else $error("parked result with empty output register");
`endif

endmodule

[design/lfl_link_ram.sv]
// single-port link memory with registered read data
module lfl_link_ram #(
    parameter int AW = 12,
    parameter int DW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/sv/lfl_tb_pkg.sv]
// scoreboard of the linked free-list allocator testbench
`timescale 1ns / 1ps
package lfl_tb_pkg;
    import lfl_pkg::*;

    localparam int LINK_DEPTH = 4096;

    typedef struct packed {
        logic [BLK_W-1:0] block;
        logic [BLK_W-1:0] count;
        t_status          status;
    } alloc_result_t;

    class free_list_board;
        logic [BLK_W-1:0] link_mem [LINK_DEPTH];
        bit               link_set [LINK_DEPTH];
        logic [BLK_W-1:0] head;
        logic [BLK_W-1:0] tail;
        logic [BLK_W-1:0] count;
        logic [TOT_W-1:0] total;
        alloc_result_t    awaited [$];
        int unsigned      mismatches;

        function new();
            head       = '0;
            tail       = '0;
            count      = '0;
            total      = TOTAL_RESET;
            mismatches = 0;
            foreach (link_set[k]) link_set[k] = 1'b0;
        endfunction

        // total as the block uses it
        function int unsigned usable_total();
            int unsigned t = total;
            if (t < TOTAL_MIN) t = TOTAL_MIN;
            if (t > LINK_DEPTH) t = LINK_DEPTH;
            return t;
        endfunction

        function void put_link(int unsigned idx, int unsigned val);
            if (idx < LINK_DEPTH) begin
                link_mem[idx] = BLK_W'(val);
                link_set[idx] = 1'b1;
            end
        endfunction

        // an allocate only reads the link of the head when the list is not empty
        function bit head_readable();
            return count == '0 || link_set[head];
        endfunction

        function alloc_result_t note_request(t_func f, logic [BLK_W-1:0] b);
            alloc_result_t r;
            int unsigned   t;
            r.block  = '0;
            r.status = ST_OK;
            t = usable_total();
            case (f)
                FUNC_FORMAT: begin
                    for (int unsigned k = FIRST_FREE; k + 1 < t; k++) put_link(k, k + 1);
                    put_link(t - 1, 0);
                    head  = FIRST_FREE;
                    tail  = BLK_W'(t - 1);
                    count = BLK_W'(t - FIRST_FREE);
                end
                FUNC_ALLOC: begin
                    if (count == '0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.block = head;
                        head    = link_mem[head];
                        count   = count - 1'b1;
                    end
                end
                FUNC_FREE: begin
                    if (b < FIRST_FREE || b >= t) begin
                        r.status = ST_BAD_BLOCK;
                    end else begin
                        if (count == '0) head = b;
                        else put_link(tail, b);
                        put_link(b, 0);
                        tail = b;
                        if (count != COUNT_MAX) count = count + 1'b1;
                    end
                end
                default: ;
            endcase
            r.count = count;
            awaited.push_back(r);
            return r;
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10) $display("mismatch in %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void check_result(logic [BLK_W-1:0] blk, logic [BLK_W-1:0] cnt,
                                   logic [STAT_W-1:0] st);
            alloc_result_t r;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: block %0d count %0d status %0d", blk, cnt, st);
                return;
            end
            r = awaited.pop_front();
            if (blk !== r.block) flag("block_out", 32'(r.block), 32'(blk));
            if (cnt !== r.count) flag("free_count", 32'(r.count), 32'(cnt));
            if (st !== r.status) flag("status", 32'(r.status), 32'(st));
        endfunction
    endclass

endpackage

[tb/sv/tb_linked_free_list_block_allocator_top.sv]
// testbench top of the linked free-list allocator: directed and random requests, checked
// against a shadow free list
`timescale 1ns / 1ps
module tb_linked_free_list_block_allocator_top;
    import lfl_pkg::*;
    import lfl_tb_pkg::*;

    // total_blocks lives at byte address 4 * its register index
    localparam logic [2:0] TOTAL_ADDR = 3'(REG_TOTAL) << 2;
    localparam int         ITEMS_PER_PHASE = 48;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lfl_in_if  req_if ();
    lfl_out_if res_if ();

    linked_free_list_block_allocator_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    free_list_board board = new();

    // idle rates in percent of cycles, per side
    int unsigned send_gap_pct = 16;
    int unsigned take_gap_pct = 64;
    // long receiver hold-off, raised by its own counting process
    logic        hold_off = 1'b0;
    // blocks handed out by allocates, candidates for well-formed frees
    logic [BLK_W-1:0] lent_blocks [$];

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // result side: check every accepted item, then pick ready for the next cycle
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                board.check_result(res_if.block_out, res_if.free_count, res_if.status);
            res_if.ready <= !hold_off && ($urandom_range(99) >= take_gap_pct);
        end
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // apb write of total_blocks, followed by a readback
    task automatic set_total(input logic [TOT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOTAL_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.total = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        // readback
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[TOT_W-1:0] !== value)
            board.flag("total_blocks readback", 32'(value), 32'(prdata[TOT_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // offer one request, with a random gap before it; valid stays high after
    // acceptance so back-to-back items do not drop valid in between
    task automatic send_request(input t_func f, input logic [BLK_W-1:0] b);
        alloc_result_t r;
        while ($urandom_range(99) < send_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.func     <= f;
        req_if.block_in <= b;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        r = board.note_request(f, b);
        if (f == FUNC_ALLOC && r.status == ST_OK) lent_blocks.push_back(r.block);
        if (f == FUNC_FORMAT) lent_blocks.delete();
    endtask

    // stop offering and let every awaited result come out
    task automatic drain();
        req_if.valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly allocates and frees of lent blocks, some stray frees, nops and formats
    task automatic random_request();
        int unsigned      t;
        int unsigned      roll;
        int unsigned      pick;
        int unsigned      idx;
        t_func            f;
        logic [BLK_W-1:0] b;
        t    = board.usable_total();
        roll = $urandom_range(99);
        b    = BLK_W'($urandom_range(4095));
        if (roll < ((t > 512) ? 1 : 4)) begin
            f = FUNC_FORMAT;
        end else if (roll < 8) begin
            f = FUNC_NOP;
        end else if (roll < 52) begin
            f = FUNC_ALLOC;
        end else begin
            f    = FUNC_FREE;
            pick = $urandom_range(99);
            if (pick < 60 && lent_blocks.size() != 0) begin
                idx = $urandom_range(lent_blocks.size() - 1);
                b   = lent_blocks[idx];
                lent_blocks.delete(idx);
            end else if (pick < 80) begin
                b = BLK_W'($urandom_range(t - 1, FIRST_FREE));
            end
        end
        // a double free can leave the head pointing at a block whose link
        // was never written; only a format makes the list usable again
        if (f == FUNC_ALLOC && !board.head_readable()) f = FUNC_FORMAT;
        send_request(f, b);
    endtask

    // one random phase: new total, format, then random traffic
    task automatic run_phase(input logic [TOT_W-1:0] total_value, input bit squeeze);
        set_total(total_value);
        send_request(FUNC_FORMAT, BLK_W'($urandom_range(4095)));
        if (squeeze) begin
            // receiver holds off while the sender keeps offering, so the
            // output registers fill and the input stalls
            fork
                begin
                    hold_off <= 1'b1;
                    repeat (300) @(posedge i_clk);
                    hold_off <= 1'b0;
                end
            join_none
        end
        repeat (ITEMS_PER_PHASE - 1) random_request();
        drain();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        req_if.valid    <= 1'b0;
        req_if.func     <= FUNC_NOP;
        req_if.block_in <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset the list is empty and total is 4096
        send_request(FUNC_ALLOC, 12'd0);     // empty list
        send_request(FUNC_NOP, 12'hfff);     // unused code reports the count
        send_request(FUNC_FREE, 12'd0);      // reserved blocks are rejected
        send_request(FUNC_FREE, 12'd1);
        send_request(FUNC_FREE, 12'd2);
        send_request(FUNC_FREE, 12'd4095);   // into empty list: head and tail
        send_request(FUNC_FREE, 12'd7);      // append at tail
        send_request(FUNC_ALLOC, 12'd0);
        send_request(FUNC_ALLOC, 12'd0);     // takes the last block
        send_request(FUNC_ALLOC, 12'd0);
        drain();

        // smallest device
        set_total(13'd4);
        send_request(FUNC_FREE, 12'd4);      // at the total, rejected
        send_request(FUNC_FREE, 12'd3);
        send_request(FUNC_FORMAT, 12'd0);
        send_request(FUNC_ALLOC, 12'hfff);
        send_request(FUNC_ALLOC, 12'd0);
        drain();

        // below the minimum, clamped up to 4
        set_total(13'd0);
        send_request(FUNC_FORMAT, 12'd0);
        send_request(FUNC_FREE, 12'd4095);   // out of range
        drain();

        // above the maximum, clamped to 4096; double frees drive the count
        // into saturation
        set_total(13'h1fff);
        send_request(FUNC_FORMAT, 12'd0);
        send_request(FUNC_FREE, 12'd4095);
        send_request(FUNC_FREE, 12'd4095);
        send_request(FUNC_FREE, 12'd4095);
        send_request(FUNC_ALLOC, 12'd0);
        send_request(FUNC_NOP, 12'd0);
        drain();

        // sender idles lightly, receiver heavily
        run_phase(13'd5, 1'b0);
        run_phase(13'h1fff, 1'b0);
        run_phase(13'd9, 1'b1);
        run_phase(13'd0, 1'b0);

        // the other way round
        send_gap_pct = 64;
        take_gap_pct = 16;
        run_phase(13'd16, 1'b0);
        run_phase(13'd4096, 1'b0);
        run_phase(13'd3, 1'b0);

        // no idling
        send_gap_pct = 0;
        take_gap_pct = 0;
        run_phase(13'd40, 1'b0);
        run_phase(13'd4097, 1'b0);
        run_phase(13'd100, 1'b1);
        run_phase(13'd4, 1'b0);

        // watch for stray results before the verdict
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
design/lfl_pkg.sv
design/lfl_if.sv
design/lfl_link_ram.sv
design/linked_free_list_block_allocator_top.sv
tb/sv/lfl_tb_pkg.sv
tb/sv/tb_linked_free_list_block_allocator_top.sv
